FILE: rtl/packet_header_ack_window_unit_defines.svh
// assertion macros for the packet header ack window unit
// depends on: a clk and an active-low rst_n in the module that expands them
`ifndef PACKET_HEADER_ACK_WINDOW_UNIT_DEFINES_SVH
`define PACKET_HEADER_ACK_WINDOW_UNIT_DEFINES_SVH

// same-cycle implication, checked while out of reset
`define PHAW_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("phaw same-cycle check failed");

// next-cycle implication, checked while out of reset
`define PHAW_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("phaw next-cycle check failed");

`endif

FILE: rtl/phaw_pkg.sv
// shared types and constants for the packet header ack window unit
// no dependencies
`default_nettype none

package phaw_pkg;

  localparam int SEQ_W       = 29;
  localparam int WORD_W      = 32;
  localparam int LEN_W       = 16;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [WORD_W-1:0] OOB_WORD = '1;
  localparam logic [LEN_W-1:0] MIN_LEN_ANY   = 16'd4;
  localparam logic [LEN_W-1:0] MIN_LEN_UNREL = 16'd8;
  localparam logic [LEN_W-1:0] MIN_LEN_REL   = 16'd12;

  typedef enum logic [1:0] {
    KIND_OOB   = 2'd0,
    KIND_UNREL = 2'd1,
    KIND_REL   = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_SHORT = 3'd1,
    ST_AHEAD = 3'd2,
    ST_DUP   = 3'd3,
    ST_OLD   = 3'd4
  } status_t;

  typedef struct packed {
    logic [WORD_W-1:0] first_word;
    logic [WORD_W-1:0] second_word;
    logic [WORD_W-1:0] third_word;
    logic [LEN_W-1:0]  packet_length;
  } in_item_t;

  typedef struct packed {
    logic              accept;
    kind_t             packet_kind;
    status_t           status;
    logic              ack_valid;
    logic [WORD_W-1:0] peer_ack;
    logic [WORD_W-1:0] peer_ack_bits;
    logic [WORD_W-1:0] local_ack_bits;
    logic [SEQ_W-1:0]  current_sequence;
  } out_item_t;

  // classified header as it waits between front and back
  typedef struct packed {
    kind_t             kind;
    logic              too_short;
    logic [SEQ_W-1:0]  seq;
    logic [WORD_W-1:0] peer_ack;
    logic [WORD_W-1:0] peer_ack_bits;
  } entry_t;

endpackage

`default_nettype wire

FILE: rtl/packet_header_ack_window_unit.sv
// packet header ack window unit: receive-side header check with a sliding ack window
// depends on: phaw_pkg, phaw_front, phaw_queue, phaw_back
//
// usage:
//   in_valid/in_ready/in_data carry one datagram header per transaction (words 0..2 and
//   the length). out_valid/out_ready/out_data carry one result per header, in order.
//   the front classifies the header and checks its length, a two-entry queue holds it,
//   and the back runs the sequence window update and loads the result register.
//   path: an accepted header is written into the queue, then moved into the result
//   register as soon as that register is free, which starts its result transaction.
//   throughput: one header per cycle while in_ready and out_ready stay high; the window
//   compare, subtract and shift of the back end are combinational, so no header waits.
//   reset: newest sequence and receive map clear, queue and result register empty.
//   stall: with out_ready low the result register holds its transaction; the queue keeps
//   taking headers until both entries are full, then in_ready drops.
//   WINDOW_BITS sets the receive map width; local_ack_bits shows its low 32 bits.
`default_nettype none

module packet_header_ack_window_unit #(
  parameter int WINDOW_BITS = 32
) (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      in_valid,
  output logic                     in_ready,
  input  wire phaw_pkg::in_item_t  in_data,
  output logic                     out_valid,
  input  wire                      out_ready,
  output phaw_pkg::out_item_t      out_data
);

  phaw_pkg::entry_t front_entry;
  phaw_pkg::entry_t q_head;
  logic             q_full;
  logic             q_not_empty;
  logic             q_pop;

  assign in_ready = !q_full;

  // classify
  phaw_front u_front (
    .item  (in_data),
    .entry (front_entry)
  );

  // decouple front and back
  phaw_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_valid && !q_full),
    .push_data (front_entry),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  // window update and result
  phaw_back #(
    .WINDOW_BITS (WINDOW_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_not_empty),
    .q_data    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

FILE: rtl/phaw_front.sv
// front end: classifies a header and checks its minimum length
// depends on: phaw_pkg
`default_nettype none

module phaw_front (
  input  wire phaw_pkg::in_item_t item,
  output phaw_pkg::entry_t        entry
);

  phaw_pkg::kind_t kind;
  logic            short_any;
  logic            short_class;

  // class from word 0
  always_comb begin
    if (item.first_word == phaw_pkg::OOB_WORD) begin
      kind = phaw_pkg::KIND_OOB;
    end else if (!item.first_word[phaw_pkg::WORD_W-1]) begin
      kind = phaw_pkg::KIND_UNREL;
    end else begin
      kind = phaw_pkg::KIND_REL;
    end
  end

  // minimum length per class
  always_comb begin
    short_any = item.packet_length < phaw_pkg::MIN_LEN_ANY;
    case (kind)
      phaw_pkg::KIND_UNREL: short_class = item.packet_length < phaw_pkg::MIN_LEN_UNREL;
      phaw_pkg::KIND_REL:   short_class = item.packet_length < phaw_pkg::MIN_LEN_REL;
      default:              short_class = 1'b0;
    endcase
  end

  // peer ack words sit one word later in reliable headers
  always_comb begin
    entry.kind      = kind;
    entry.too_short = short_any | short_class;
    entry.seq       = item.first_word[phaw_pkg::SEQ_W-1:0];
    if (kind == phaw_pkg::KIND_UNREL) begin
      entry.peer_ack      = item.first_word;
      entry.peer_ack_bits = item.second_word;
    end else begin
      entry.peer_ack      = item.second_word;
      entry.peer_ack_bits = item.third_word;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/phaw_queue.sv
// two-entry queue of classified headers between front and back
// depends on: phaw_pkg
`default_nettype none

module phaw_queue (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    push,
  input  wire phaw_pkg::entry_t  push_data,
  output logic                   full,
  input  wire                    pop,
  output logic                   not_empty,
  output phaw_pkg::entry_t       head
);

  localparam int PTR_W = $clog2(phaw_pkg::QUEUE_DEPTH);
  localparam int CNT_W = $clog2(phaw_pkg::QUEUE_DEPTH + 1);

  phaw_pkg::entry_t   slot_r [phaw_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;

  assign full      = count_r == CNT_W'(phaw_pkg::QUEUE_DEPTH);
  assign not_empty = count_r != '0;
  assign head      = slot_r[rd_ptr_r];

  // pointer and fill count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(phaw_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(phaw_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({push, pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/phaw_back.sv
// back end: sliding receive window update and result register
// depends on: phaw_pkg, packet_header_ack_window_unit_defines.svh
`default_nettype none
`include "packet_header_ack_window_unit_defines.svh"

module phaw_back #(
  parameter int WINDOW_BITS = 32
) (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     q_valid,
  input  wire phaw_pkg::entry_t   q_data,
  output logic                    q_pop,
  output logic                    out_valid,
  input  wire                     out_ready,
  output phaw_pkg::out_item_t     out_data
);

  localparam int SEQ_W = phaw_pkg::SEQ_W;
  localparam int DW    = $clog2(WINDOW_BITS + 2);
  localparam int IW    = $clog2(WINDOW_BITS);
  localparam logic [DW-1:0] W_D = DW'(WINDOW_BITS);

  logic [SEQ_W-1:0]       newest_r, newest_nxt;
  logic [WINDOW_BITS-1:0] map_r, map_nxt;
  logic                   out_valid_r;
  phaw_pkg::out_item_t    out_r, res;

  logic [SEQ_W:0]         ahead_limit;
  logic                   is_ahead, is_newer, is_equal, is_old;
  logic [SEQ_W-1:0]       fwd_dist, back_dist;
  logic [DW-1:0]          fwd_small, back_small, fwd_pos, back_pos;
  logic [WINDOW_BITS-1:0] fwd_map, fwd_mark, back_mark;
  phaw_pkg::status_t      seq_status;

  // take the queue head whenever the result register frees up
  assign q_pop     = q_valid && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // sequence compares against the newest received
  always_comb begin
    ahead_limit = {1'b0, newest_r} + (SEQ_W + 1)'(WINDOW_BITS + 1);
    is_ahead    = {1'b0, q_data.seq} > ahead_limit;
    is_newer    = q_data.seq > newest_r;
    is_equal    = q_data.seq == newest_r;
    fwd_dist    = q_data.seq - newest_r;
    back_dist   = newest_r - q_data.seq;
    is_old      = back_dist > SEQ_W'(WINDOW_BITS);
    fwd_small   = fwd_dist[DW-1:0];
    back_small  = back_dist[DW-1:0];
    fwd_pos     = W_D - fwd_small;
    back_pos    = W_D - back_small;
    fwd_map     = map_r >> fwd_small;
    fwd_mark    = (fwd_small <= W_D) ? (WINDOW_BITS'(1) << fwd_pos[IW-1:0]) : '0;
    back_mark   = WINDOW_BITS'(1) << back_pos[IW-1:0];
  end

  // window verdict for a reliable datagram
  always_comb begin
    if (is_ahead) begin
      seq_status = phaw_pkg::ST_AHEAD;
    end else if (is_newer) begin
      seq_status = phaw_pkg::ST_OK;
    end else if (is_equal) begin
      seq_status = phaw_pkg::ST_DUP;
    end else if (is_old) begin
      seq_status = phaw_pkg::ST_OLD;
    end else if ((map_r & back_mark) != '0) begin
      seq_status = phaw_pkg::ST_DUP;
    end else begin
      seq_status = phaw_pkg::ST_OK;
    end
  end

  // state update and result
  always_comb begin
    newest_nxt = newest_r;
    map_nxt    = map_r;
    res        = '0;
    res.packet_kind = q_data.kind;
    res.status      = phaw_pkg::ST_OK;
    if (q_data.too_short) begin
      res.status = phaw_pkg::ST_SHORT;
    end else begin
      case (q_data.kind)
        phaw_pkg::KIND_OOB: begin
          res.accept = 1'b1;
        end
        phaw_pkg::KIND_UNREL: begin
          res.accept    = 1'b1;
          res.ack_valid = 1'b1;
        end
        default: begin
          res.status = seq_status;
          if (seq_status == phaw_pkg::ST_OK) begin
            res.accept    = 1'b1;
            res.ack_valid = 1'b1;
            if (is_newer) begin
              newest_nxt = q_data.seq;
              map_nxt    = fwd_map | fwd_mark;
            end else begin
              map_nxt = map_r | back_mark;
            end
          end
        end
      endcase
    end
    if (res.ack_valid) begin
      res.peer_ack      = q_data.peer_ack;
      res.peer_ack_bits = q_data.peer_ack_bits;
    end
    res.local_ack_bits   = 32'(map_nxt);
    res.current_sequence = newest_nxt;
  end

  // window state and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      newest_r    <= '0;
      map_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (q_pop) begin
        newest_r    <= newest_nxt;
        map_r       <= map_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_r <= res;
    end
  end

  // checks
  `PHAW_ASSERT_NEXT(a_state_only_on_pop, !q_pop, $stable(newest_r) && $stable(map_r))
  `PHAW_ASSERT_NEXT(a_pop_fills_result, q_pop, out_valid_r)
  `PHAW_ASSERT_NOW(a_ack_needs_accept, out_valid_r && out_r.ack_valid,
                   out_r.accept && out_r.packet_kind != phaw_pkg::KIND_OOB)
  `PHAW_ASSERT_NEXT(a_newest_never_drops, q_pop, newest_r >= $past(newest_r))

endmodule

`default_nettype wire

FILE: test/phaw_verdict_checker.sv
// verdict checker for the packet header ack window unit: watches both channels,
// predicts each header's verdict and compares it with the block's output
// depends on: phaw_pkg
`timescale 1ns / 100ps

module phaw_verdict_checker (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  input  wire                  in_ready,
  input  phaw_pkg::in_item_t   in_data,
  input  wire                  out_valid,
  input  wire                  out_ready,
  input  phaw_pkg::out_item_t  out_data,
  output int                   fail_count,
  output int                   verdicts_waiting
);

  localparam int WIN   = 32;
  localparam int SEQ_W = phaw_pkg::SEQ_W;

  // own copy of the receive window
  logic [SEQ_W-1:0] newest_seq;
  logic [WIN-1:0]   recv_map;

  phaw_pkg::out_item_t pending_verdicts[$];
  int                  mismatches;

  // window check for a reliable sequence, updates the window when it is taken
  function automatic phaw_pkg::status_t slide_window(logic [SEQ_W-1:0] seq);
    logic [63:0] s;
    logic [63:0] n;
    logic [63:0] d;
    logic [63:0] back;
    logic [63:0] m;
    s = seq;
    n = newest_seq;
    if (s > n + WIN + 1)
      return phaw_pkg::ST_AHEAD;
    if (s > n) begin
      d = s - n;
      m = {32'b0, recv_map} >> d;
      // the previous newest sequence drops out when the jump is one past the window
      if (d <= WIN)
        m = m | (64'd1 << (WIN - d));
      recv_map = m[WIN-1:0];
      newest_seq = seq;
      return phaw_pkg::ST_OK;
    end
    if (s == n)
      return phaw_pkg::ST_DUP;
    back = n - s;
    if (back > WIN)
      return phaw_pkg::ST_OLD;
    if (recv_map[WIN - back])
      return phaw_pkg::ST_DUP;
    recv_map[WIN - back] = 1'b1;
    return phaw_pkg::ST_OK;
  endfunction

  // expected verdict for one header
  function automatic phaw_pkg::out_item_t classify_header(phaw_pkg::in_item_t hdr);
    phaw_pkg::out_item_t v;
    phaw_pkg::kind_t     kind;
    v = '0;
    if (hdr.first_word == phaw_pkg::OOB_WORD)
      kind = phaw_pkg::KIND_OOB;
    else if (!hdr.first_word[phaw_pkg::WORD_W-1])
      kind = phaw_pkg::KIND_UNREL;
    else
      kind = phaw_pkg::KIND_REL;
    v.packet_kind = kind;
    v.status = phaw_pkg::ST_OK;
    if (hdr.packet_length < phaw_pkg::MIN_LEN_ANY) begin
      v.status = phaw_pkg::ST_SHORT;
    end else begin
      case (kind)
        phaw_pkg::KIND_OOB: begin
          v.accept = 1'b1;
        end
        phaw_pkg::KIND_UNREL: begin
          if (hdr.packet_length < phaw_pkg::MIN_LEN_UNREL) begin
            v.status = phaw_pkg::ST_SHORT;
          end else begin
            v.accept = 1'b1;
            v.ack_valid = 1'b1;
            v.peer_ack = hdr.first_word;
            v.peer_ack_bits = hdr.second_word;
          end
        end
        default: begin
          if (hdr.packet_length < phaw_pkg::MIN_LEN_REL) begin
            v.status = phaw_pkg::ST_SHORT;
          end else begin
            v.status = slide_window(hdr.first_word[SEQ_W-1:0]);
            if (v.status == phaw_pkg::ST_OK) begin
              v.accept = 1'b1;
              v.ack_valid = 1'b1;
              v.peer_ack = hdr.second_word;
              v.peer_ack_bits = hdr.third_word;
            end
          end
        end
      endcase
    end
    v.local_ack_bits = recv_map[31:0];
    v.current_sequence = newest_seq;
    return v;
  endfunction

  // field by field comparison against the oldest expected verdict
  task automatic compare_verdict(phaw_pkg::out_item_t got, phaw_pkg::out_item_t want);
    if (got.accept !== want.accept) begin
      $error("accept: expected %0d actual %0d", want.accept, got.accept);
      mismatches++;
    end
    if (got.packet_kind !== want.packet_kind) begin
      $error("packet_kind: expected %0d actual %0d", want.packet_kind, got.packet_kind);
      mismatches++;
    end
    if (got.status !== want.status) begin
      $error("status: expected %0d actual %0d", want.status, got.status);
      mismatches++;
    end
    if (got.ack_valid !== want.ack_valid) begin
      $error("ack_valid: expected %0d actual %0d", want.ack_valid, got.ack_valid);
      mismatches++;
    end
    if (got.peer_ack !== want.peer_ack) begin
      $error("peer_ack: expected %08h actual %08h", want.peer_ack, got.peer_ack);
      mismatches++;
    end
    if (got.peer_ack_bits !== want.peer_ack_bits) begin
      $error("peer_ack_bits: expected %08h actual %08h", want.peer_ack_bits,
             got.peer_ack_bits);
      mismatches++;
    end
    if (got.local_ack_bits !== want.local_ack_bits) begin
      $error("local_ack_bits: expected %08h actual %08h", want.local_ack_bits,
             got.local_ack_bits);
      mismatches++;
    end
    if (got.current_sequence !== want.current_sequence) begin
      $error("current_sequence: expected %0h actual %0h", want.current_sequence,
             got.current_sequence);
      mismatches++;
    end
  endtask

  // result side is handled before the header of the same edge is predicted
  always @(posedge clk) begin
    if (!rst_n) begin
      newest_seq = '0;
      recv_map = '0;
      pending_verdicts.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (pending_verdicts.size() == 0) begin
          $error("unexpected result transaction: nothing was waiting");
          mismatches++;
        end else begin
          compare_verdict(out_data, pending_verdicts.pop_front());
        end
      end
      if (in_valid && in_ready)
        pending_verdicts.insert(pending_verdicts.size(), classify_header(in_data));
    end
    fail_count = mismatches;
    verdicts_waiting = pending_verdicts.size();
  end

endmodule

FILE: test/tb_packet_header_ack_window_unit.sv
// top of the packet header ack window unit bench: clock, reset, header stimulus
// and result back-pressure; prediction and checking sit in phaw_verdict_checker
// depends on: phaw_pkg, packet_header_ack_window_unit, phaw_verdict_checker
`timescale 1ns / 100ps

module tb_packet_header_ack_window_unit;

  localparam int RANDOM_HEADERS = 2000;
  localparam int CALM_TAIL      = 300;
  localparam logic [phaw_pkg::WORD_W-1:0] REL_FLAG = 32'h8000_0000;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  phaw_pkg::in_item_t  in_data;
  logic                out_valid;
  logic                out_ready;
  phaw_pkg::out_item_t out_data;
  int                  fail_count;
  int                  verdicts_waiting;
  logic                calm;

  // highest reliable sequence sent that should have moved the window
  logic [63:0] window_head;

  // directed headers collected before they are sent
  phaw_pkg::in_item_t directed_headers[$];

  packet_header_ack_window_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  phaw_verdict_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data          (in_data),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_data         (out_data),
    .fail_count       (fail_count),
    .verdicts_waiting (verdicts_waiting)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  function automatic phaw_pkg::in_item_t make_header(logic [31:0] w0, logic [31:0] w1,
                                                     logic [31:0] w2, logic [15:0] len);
    phaw_pkg::in_item_t h;
    h.first_word = w0;
    h.second_word = w1;
    h.third_word = w2;
    h.packet_length = len;
    return h;
  endfunction

  // append one header to the directed list
  task automatic stage_header(phaw_pkg::in_item_t hdr);
    directed_headers.insert(directed_headers.size(), hdr);
  endtask

  // present one header and hold it until the transaction completes
  task automatic send_header(phaw_pkg::in_item_t hdr);
    @(negedge clk);
    in_valid <= 1'b1;
    in_data <= hdr;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic idle_input(int cycles);
    @(negedge clk);
    in_valid <= 1'b0;
    repeat (cycles - 1) @(negedge clk);
  endtask

  function automatic logic [15:0] pick_length(logic [15:0] floor_len);
    if ($urandom_range(0, 9) == 0)
      return 16'($urandom_range(0, 11));
    if ($urandom_range(0, 1) == 0)
      return 16'($urandom_range(floor_len, 1500));
    return 16'($urandom_range(floor_len, 65535));
  endfunction

  // reliable header whose sequence lands around the current window
  function automatic phaw_pkg::in_item_t make_reliable();
    logic [63:0] seq;
    logic [63:0] step;
    logic [15:0] len;
    logic [31:0] w0;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: seq = window_head + $urandom_range(1, 3);
      4:          seq = window_head + $urandom_range(4, 33);
      5:          seq = window_head + $urandom_range(33, 34);
      6, 7: begin
        step = $urandom_range(1, 32);
        seq = (window_head > step) ? window_head - step : 64'd0;
      end
      8: begin
        step = $urandom_range(33, 40);
        seq = (window_head > step) ? window_head - step : 64'd0;
      end
      default:    seq = window_head;
    endcase
    len = pick_length(phaw_pkg::MIN_LEN_REL);
    w0 = REL_FLAG | (32'($urandom_range(0, 3)) << phaw_pkg::SEQ_W)
         | 32'(seq[phaw_pkg::SEQ_W-1:0]);
    if (len >= phaw_pkg::MIN_LEN_REL && seq > window_head && seq <= window_head + 33)
      window_head = seq;
    return make_header(w0, $urandom, $urandom, len);
  endfunction

  function automatic phaw_pkg::in_item_t make_random_header();
    logic [31:0] w0;
    case ($urandom_range(0, 19))
      0, 1: begin
        return make_header(phaw_pkg::OOB_WORD, $urandom, $urandom,
                           pick_length(phaw_pkg::MIN_LEN_ANY));
      end
      2, 3, 4: begin
        w0 = $urandom & 32'h7FFF_FFFF;
        return make_header(w0, $urandom, $urandom, pick_length(phaw_pkg::MIN_LEN_UNREL));
      end
      5:       return make_header($urandom, $urandom, $urandom, 16'($urandom));
      default: return make_reliable();
    endcase
  endfunction

  // result back-pressure in bursts, none in the calm tail
  initial begin
    int span;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!calm && $urandom_range(0, 3) == 0) begin
        span = $urandom_range(1, 13);
        out_ready <= 1'b0;
      end else begin
        span = $urandom_range(1, 20);
        out_ready <= 1'b1;
      end
      repeat (span - 1) @(negedge clk);
    end
  end

  // run limit
  initial begin
    #2_000_000;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    calm = 1'b0;
    window_head = 64'd0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    // directed: length floors per class, window edges from the reset state
    stage_header(make_header(phaw_pkg::OOB_WORD, '0, '0, 16'd0));
    stage_header(make_header(phaw_pkg::OOB_WORD, '1, '1, 16'd3));
    stage_header(make_header(phaw_pkg::OOB_WORD, '0, '0, 16'd4));
    stage_header(make_header(32'h0, '1, '1, 16'd7));
    stage_header(make_header(32'h7FFF_FFFF, '1, '1, 16'd8));
    stage_header(make_header(32'h0, '0, '0, 16'd8));
    stage_header(make_header(REL_FLAG, '1, '1, 16'd11));
    // sequence zero equals the reset head: duplicate
    stage_header(make_header(REL_FLAG, '1, '1, 16'd12));
    stage_header(make_header(32'hE000_0001, '1, '1, 16'hFFFF));
    // one past the reach of the window: too far ahead
    stage_header(make_header(REL_FLAG | 32'd35, 32'h1234, 32'h5678, 16'd12));
    // jump of window plus one, previous head falls off
    stage_header(make_header(REL_FLAG | 32'd34, 32'hA5A5_A5A5, 32'h5A5A_5A5A, 16'd20));
    // oldest slot of the window, then again as duplicate
    stage_header(make_header(REL_FLAG | 32'd2, '0, '1, 16'd12));
    stage_header(make_header(REL_FLAG | 32'd2, '0, '1, 16'd12));
    // just behind the window: too old
    stage_header(make_header(REL_FLAG | 32'd1, '1, '0, 16'd12));
    stage_header(make_header(REL_FLAG | 32'd34, '1, '0, 16'd12));
    stage_header(make_header(32'hA000_0023, '1, '1, 16'd100));
    stage_header(make_header(REL_FLAG | 32'd33, '0, '0, 16'd12));
    stage_header(make_header(32'hFFFF_FFFE, '1, '1, 16'hFFFF));
    stage_header(make_header(phaw_pkg::OOB_WORD, '1, '1, 16'hFFFF));
    foreach (directed_headers[i])
      send_header(directed_headers[i]);
    window_head = 64'd35;

    // random headers, mostly well-formed reliable traffic around the window
    for (int i = 0; i < RANDOM_HEADERS; i++) begin
      if (i == RANDOM_HEADERS - CALM_TAIL)
        calm = 1'b1;
      if (!calm && $urandom_range(0, 4) == 0)
        idle_input($urandom_range(1, 13));
      send_header(make_random_header());
    end
    @(negedge clk);
    in_valid <= 1'b0;

    // drain: wait for every expected verdict, then watch on for strays
    wait (verdicts_waiting == 0);
    repeat (6) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+rtl
rtl/phaw_pkg.sv
rtl/phaw_front.sv
rtl/phaw_queue.sv
rtl/phaw_back.sv
rtl/packet_header_ack_window_unit.sv
test/phaw_verdict_checker.sv
test/tb_packet_header_ack_window_unit.sv
